>>> rtl/pmsd_pkg.sv
// ----------------------------------------------------------------------------
// pmsd_pkg: shared types and constants
// Field widths, saturation limit, cell control bundle and sequencer states.
// ----------------------------------------------------------------------------
package pmsd_pkg;

  localparam int unsigned VAL_W = 16;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned CFG_W = 5;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Register index of max_run_length
  localparam logic REG_MAX_RUN_LEN = 1'b0;

  // One move of the history chain per cycle, at most one bit set
  typedef struct packed {
    logic clear;   // drop the history (end of array)
    logic shift;   // push a new entry in at cell 0
    logic rotate;  // circular move toward cell 0
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

endpackage

>>> rtl/pmsd_cell.sv
// ----------------------------------------------------------------------------
// pmsd_cell: one history cell
// Holds one past element and the best sum before it; moves data to a neighbor.
// ----------------------------------------------------------------------------
module pmsd_cell (
  input  logic                         clk_i,
  input  pmsd_pkg::cell_ctrl_t         ctrl_i,
  input  logic [pmsd_pkg::VAL_W-1:0]   shift_val_i,
  input  logic [pmsd_pkg::SUM_W-1:0]   shift_sum_i,
  input  logic [pmsd_pkg::VAL_W-1:0]   rot_val_i,
  input  logic [pmsd_pkg::SUM_W-1:0]   rot_sum_i,
  output logic [pmsd_pkg::VAL_W-1:0]   val_o,
  output logic [pmsd_pkg::SUM_W-1:0]   sum_o
);

  logic [pmsd_pkg::VAL_W-1:0] val_q, val_d;
  logic [pmsd_pkg::SUM_W-1:0] sum_q, sum_d;

  always_comb begin
    val_d = val_q;
    sum_d = sum_q;
    if (ctrl_i.clear) begin
      val_d = '0;
      sum_d = '0;
    end else if (ctrl_i.shift) begin
      val_d = shift_val_i;
      sum_d = shift_sum_i;
    end else if (ctrl_i.rotate) begin
      val_d = rot_val_i;
      sum_d = rot_sum_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    sum_q <= sum_d;
  end

  assign val_o = val_q;
  assign sum_o = sum_q;

endmodule

>>> rtl/partition_max_sum_dp.sv
// ----------------------------------------------------------------------------
// partition_max_sum_dp: streaming partition-array-for-maximum-sum
// Sequencing: each accepted item is evaluated in ST_EVAL, where the history
//   chain rotates once per candidate run length; ST_UPD then writes the new
//   entry and the result once the output is free, and may take the next item.
// Reset (async, rst_ni low): sequencer idle, output empty, run length 1,
//   element count zero; history contents are masked by the count.
// ----------------------------------------------------------------------------
module partition_max_sum_dp #(
  parameter int unsigned MAX_RUN = 16   // history depth, 1..64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] value
  input  logic        s_axis_tlast,   // last_element
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [47:0] best_sum
  output logic        m_axis_tlast,   // is_final
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned VAL_W  = pmsd_pkg::VAL_W;
  localparam int unsigned SUM_W  = pmsd_pkg::SUM_W;
  localparam int unsigned CFG_W  = pmsd_pkg::CFG_W;
  localparam int unsigned LEN_W  = $clog2(MAX_RUN + 1);
  localparam int unsigned PROD_W = VAL_W + LEN_W;
  localparam int unsigned CMP_W  = 7;  // holds MAX_RUN+1 at the top of its range

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] run_len_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == pmsd_pkg::REG_MAX_RUN_LEN);
  assign prdata = (paddr[2] == pmsd_pkg::REG_MAX_RUN_LEN) ?
                  {{(32-CFG_W){1'b0}}, run_len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_len_q <= CFG_W'(1);
    end else if (cfg_wr) begin
      run_len_q <= pwdata[CFG_W-1:0];
    end
  end

  // ---------------- control ----------------
  pmsd_pkg::state_e state_q, state_d;
  logic             m_valid_q;
  logic             out_free, in_acc, upd_go, eval_done;

  logic [VAL_W-1:0] v_q;          // item under evaluation
  logic             last_q;
  logic [LEN_W-1:0] len_q;        // current candidate run length
  logic [LEN_W-1:0] seen_q;       // elements before this one, saturating
  logic [VAL_W-1:0] run_max_q;    // max over the run so far
  logic [VAL_W-1:0] prev_val_q;   // head value one step back
  logic [SUM_W-1:0] best_q;
  logic [SUM_W-1:0] out_sum_q;
  logic             out_last_q;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign upd_go        = (state_q == pmsd_pkg::ST_UPD) && out_free;
  // a new item can enter during the write-back cycle of the previous one
  assign s_axis_tready = (state_q == pmsd_pkg::ST_IDLE) || upd_go;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign eval_done     = (len_q == LEN_W'(MAX_RUN));

  always_comb begin
    state_d = state_q;
    case (state_q)
      pmsd_pkg::ST_IDLE: if (in_acc) state_d = pmsd_pkg::ST_EVAL;
      pmsd_pkg::ST_EVAL: if (eval_done) state_d = pmsd_pkg::ST_UPD;
      pmsd_pkg::ST_UPD: begin
        if (in_acc) state_d = pmsd_pkg::ST_EVAL;
        else if (upd_go) state_d = pmsd_pkg::ST_IDLE;
      end
      default: state_d = pmsd_pkg::ST_IDLE;
    endcase
  end

  // ---------------- history chain ----------------
  logic [VAL_W-1:0]     cell_val [MAX_RUN];
  logic [SUM_W-1:0]     cell_sum [MAX_RUN];
  pmsd_pkg::cell_ctrl_t cell_ctrl;

  assign cell_ctrl.clear  = upd_go && last_q;
  assign cell_ctrl.shift  = upd_go && !last_q;
  assign cell_ctrl.rotate = (state_q == pmsd_pkg::ST_EVAL);

  // The chain makes MAX_RUN rotations per item, so it is back in order
  // (newest at cell 0) for the write-back shift.
  for (genvar i = 0; i < MAX_RUN; i++) begin : g_cell
    logic [VAL_W-1:0] sh_val;
    logic [SUM_W-1:0] sh_sum;
    if (i == 0) begin : g_head
      assign sh_val = v_q;
      assign sh_sum = best_q;
    end else begin : g_body
      assign sh_val = cell_val[i-1];
      assign sh_sum = cell_sum[i-1];
    end
    pmsd_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .shift_val_i (sh_val),
      .shift_sum_i (sh_sum),
      .rot_val_i   (cell_val[(i + 1) % MAX_RUN]),
      .rot_sum_i   (cell_sum[(i + 1) % MAX_RUN]),
      .val_o       (cell_val[i]),
      .sum_o       (cell_sum[i])
    );
  end

  // ---------------- candidate step ----------------
  // At step len the head cell holds entry len-1: its sum is dp before the
  // run, and the run's oldest element is the head value of the prior step.
  logic [CMP_W-1:0]  k_raw, k_clip, mr_c, lim_c;
  logic              active;
  logic [VAL_W-1:0]  elem, run_max_nx;
  logic [SUM_W-1:0]  prior_sum, cand_sat;
  logic [PROD_W-1:0] prod;
  logic [SUM_W:0]    cand;

  always_comb begin
    k_raw  = CMP_W'(run_len_q);
    mr_c   = CMP_W'(MAX_RUN);
    if (k_raw == '0) k_raw = CMP_W'(1);          // zero acts as one
    k_clip = (k_raw > mr_c) ? mr_c : k_raw;
    // runs never reach back past the array start
    lim_c  = ((CMP_W'(seen_q) + CMP_W'(1)) < k_clip) ?
             (CMP_W'(seen_q) + CMP_W'(1)) : k_clip;
    active = (CMP_W'(len_q) <= lim_c);

    elem       = (len_q == LEN_W'(1)) ? v_q : prev_val_q;
    run_max_nx = (elem > run_max_q) ? elem : run_max_q;
    prior_sum  = (len_q <= seen_q) ? cell_sum[0] : '0;
    prod       = PROD_W'(run_max_nx) * PROD_W'(len_q);
    cand       = {1'b0, prior_sum} + (SUM_W+1)'(prod);
    cand_sat   = cand[SUM_W] ? pmsd_pkg::SUM_MAX : cand[SUM_W-1:0];
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pmsd_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
      seen_q    <= '0;
      len_q     <= '0;
    end else begin
      state_q <= state_d;
      if (upd_go) begin
        m_valid_q <= 1'b1;
        if (last_q) seen_q <= '0;
        else if (seen_q != LEN_W'(MAX_RUN)) seen_q <= seen_q + LEN_W'(1);
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (in_acc) len_q <= LEN_W'(1);
      else if (state_q == pmsd_pkg::ST_EVAL && !eval_done) len_q <= len_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v_q       <= s_axis_tdata;
      last_q    <= s_axis_tlast;
      run_max_q <= '0;
      best_q    <= '0;
    end else if (state_q == pmsd_pkg::ST_EVAL) begin
      run_max_q <= run_max_nx;
      if (active && (cand_sat > best_q)) best_q <= cand_sat;
    end
    if (state_q == pmsd_pkg::ST_EVAL) prev_val_q <= cell_val[0];
    if (upd_go) begin
      out_sum_q  <= best_q;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_sum_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> rtl/pmsd_checker.sv
// ----------------------------------------------------------------------------
// pmsd_checker: port-level checks
// Watches the stream and register ports of partition_max_sum_dp.
// ----------------------------------------------------------------------------
module pmsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [2:0]  paddr,
  input logic [31:0] prdata
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // an accepted item keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after accept");

  // the previous result may rise with the accept; nothing new right behind it
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 !$rose(m_axis_tvalid))
    else $error("result too early");

  // only the low five register bits exist
  a_rd_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prdata[31:5] == 27'd0) && (paddr[2] == 1'b0 || prdata == 32'd0))
    else $error("read data out of range");

endmodule

bind partition_max_sum_dp pmsd_checker u_pmsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .paddr         (paddr),
  .prdata        (prdata)
);

>>> tb/partition_max_sum_dp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partition_max_sum_dp_tb: self-checking bench for partition_max_sum_dp
// Streams arrays into the block one element per item. A behavioral model of
// the run-partition recurrence predicts every running best sum, and each
// result is checked when it leaves the block. The run-length register is set
// to fixed and random values, including the zero, oversized and unmapped cases.
// Both stream sides idle at random, and one phase holds the output off long
// enough to stall the input.
// ----------------------------------------------------------------------------
module partition_max_sum_dp_tb;

  localparam int unsigned      VAL_W           = pmsd_pkg::VAL_W;
  localparam int unsigned      SUM_W           = pmsd_pkg::SUM_W;
  localparam int unsigned      CFG_W           = pmsd_pkg::CFG_W;
  localparam logic [SUM_W-1:0] SUM_MAX         = pmsd_pkg::SUM_MAX;
  localparam logic             REG_MAX_RUN_LEN = pmsd_pkg::REG_MAX_RUN_LEN;

  localparam int unsigned DEPTH      = 16;            // MAX_RUN of the instance
  localparam int unsigned LATENCY    = DEPTH + 1;
  localparam int unsigned SETTLE     = 4 * LATENCY;   // quiet time after a drain
  localparam int unsigned TIMEOUT_NS = 2_000_000;     // bench timeout, clock period 2 ns

  // Byte addresses: max_run_length at index 0. Index 1 is unmapped.
  localparam logic [2:0] ADDR_MAX_RUN_LEN = {REG_MAX_RUN_LEN, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED    = 3'b100;

  typedef struct packed {
    logic [SUM_W-1:0] best_sum;
    logic             is_final;
  } dp_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset, block ports
  // --------------------------------------------------------------------------
  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [VAL_W-1:0] s_axis_tdata  = '0;     // [15:0] value
  logic             s_axis_tlast  = 1'b0;   // last_element
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [SUM_W-1:0] m_axis_tdata;           // [47:0] best_sum
  logic             m_axis_tlast;           // is_final
  logic             psel          = 1'b0;
  logic             penable       = 1'b0;
  logic             pwrite        = 1'b0;
  logic [2:0]       paddr         = '0;
  logic [31:0]      pwdata        = '0;
  logic [31:0]      prdata;
  logic             pready;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  partition_max_sum_dp #(
    .MAX_RUN(DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  dp_result_t  expected_sums[$];     // predicted results, oldest first
  int unsigned mismatches    = 0;
  int unsigned gap_pct       = 22;   // sender idle chance per item, percent
  int unsigned stall_pct     = 22;   // receiver stall chance per cycle, percent
  int unsigned hold_request  = 0;    // long output hold-off, picked up below
  int unsigned hold_left     = 0;

  // Predictor copy of the block state; newest history entry at index 0
  logic [VAL_W-1:0] hist_val [DEPTH];
  logic [SUM_W-1:0] hist_sum [DEPTH];
  int unsigned      prefix_len;      // elements before this one, caps at DEPTH
  logic [CFG_W-1:0] run_len_cfg;

  function automatic void dp_clear();
    for (int unsigned i = 0; i < DEPTH; i++) begin
      hist_val[i] = '0;
      hist_sum[i] = '0;
    end
    prefix_len = 0;
  endfunction

  // Best sum for the prefix ending at v: try every run length that fits in
  // both k and the array, keep the largest, then push v or clear if last.
  function automatic dp_result_t dp_advance(input logic [VAL_W-1:0] v, input logic last);
    int unsigned      k;
    int unsigned      reach;
    int unsigned      len;
    logic [VAL_W-1:0] run_max;
    logic [VAL_W-1:0] elem;
    logic [63:0]      prior_sum;
    logic [63:0]      cand;
    dp_result_t       r;
    k = (run_len_cfg == 0) ? 1 : run_len_cfg;   // zero acts as one
    if (k > DEPTH) k = DEPTH;                    // oversized clamps to depth
    reach = (prefix_len + 1 < k) ? prefix_len + 1 : k;
    run_max    = '0;
    r.best_sum = '0;
    r.is_final = last;
    for (len = 1; len <= reach; len++) begin
      elem = (len == 1) ? v : hist_val[len-2];
      if (elem > run_max) run_max = elem;
      // run starting the array has nothing before it
      prior_sum = (len > prefix_len) ? 64'd0 : 64'(hist_sum[len-1]);
      cand      = 64'(run_max) * len + prior_sum;
      if (cand > 64'(SUM_MAX)) cand = 64'(SUM_MAX);
      if (cand > 64'(r.best_sum)) r.best_sum = cand[SUM_W-1:0];
    end
    if (last) begin
      dp_clear();
    end else begin
      for (int unsigned j = DEPTH - 1; j > 0; j--) begin
        hist_val[j] = hist_val[j-1];
        hist_sum[j] = hist_sum[j-1];
      end
      hist_val[0] = v;
      hist_sum[0] = r.best_sum;
      if (prefix_len < DEPTH) prefix_len++;
    end
    return r;
  endfunction

  // Extremes and small values show up often so long runs tie and switch max
  function automatic logic [VAL_W-1:0] random_element();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return VAL_W'($urandom_range(15));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Shared drivers. All tasks start and end on a falling edge.
  // --------------------------------------------------------------------------
  task automatic send_element(input logic [VAL_W-1:0] v, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_sums.push_back(dp_advance(v, last));
    @(negedge clk_i);
  endtask

  // Stop offering items and wait until every result is back
  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    while (expected_sums.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((addr >> 2) == REG_MAX_RUN_LEN) run_len_cfg = data[CFG_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_run_len_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MAX_RUN_LEN;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(run_len_cfg)) begin
      $error("max_run_length: expected %0d, got %0d", run_len_cfg, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker: every accepted result against the oldest prediction
  always @(posedge clk_i) begin : check_results
    dp_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected result: best_sum %0d is_final %0b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = expected_sums.pop_front();
        if (m_axis_tdata !== want.best_sum) begin
          $error("best_sum: expected %0d, got %0d", want.best_sum, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== want.is_final) begin
          $error("is_final: expected %0b, got %0b", want.is_final, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset run length is one: plain running sum, extremes of the value field
  task automatic test_reset_defaults();
    check_run_len_reg();
    send_element(16'h0000, 1'b0);
    send_element(16'hFFFF, 1'b0);
    send_element(16'hFFFF, 1'b1);
    drain_stream();
  endtask

  task automatic test_run_length_limits();
    // zero acts as one
    reg_write(ADDR_MAX_RUN_LEN, 32'd0);
    check_run_len_reg();
    send_element(16'd7, 1'b0);
    send_element(16'd3, 1'b1);
    drain_stream();
    // a write to an unmapped index leaves the register alone
    reg_write(ADDR_UNMAPPED, 32'd9);
    check_run_len_reg();
    // oversized run length clamps to the depth; short prefix stays in the array
    reg_write(ADDR_MAX_RUN_LEN, 32'd31);
    check_run_len_reg();
    send_element(16'd1, 1'b0);
    send_element(16'hFFFF, 1'b0);
    send_element(16'd2, 1'b0);
    send_element(16'd0, 1'b0);
    send_element(16'hFFFF, 1'b1);
    drain_stream();
    // one-element array at full depth
    reg_write(ADDR_MAX_RUN_LEN, 32'(DEPTH));
    send_element(16'hFFFF, 1'b1);
    drain_stream();
    // upper data bits are dropped: 0x...E3 lands as 3
    reg_write(ADDR_MAX_RUN_LEN, 32'hFFFF_FFE3);
    check_run_len_reg();
    send_element(16'h0000, 1'b0);
    send_element(16'hFFFF, 1'b0);
    send_element(16'h8000, 1'b0);
    send_element(16'h0000, 1'b0);
    send_element(16'hFFFF, 1'b0);
    send_element(16'h0001, 1'b1);
    drain_stream();
  endtask

  // Random arrays over a sweep of run lengths. Arrays may straddle a phase, so
  // a run-length change also lands mid-array.
  task automatic test_random_arrays();
    logic [CFG_W-1:0] k;
    int unsigned      arr_left;
    arr_left = 0;
    for (int unsigned phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       k = 5'd1;
        1:       k = 5'(DEPTH);
        2:       k = 5'd0;
        3:       k = 5'd31;
        4:       k = 5'd2;
        5:       k = 5'd5;
        default: k = 5'($urandom_range(31));
      endcase
      reg_write(ADDR_MAX_RUN_LEN, 32'(k));
      // full-depth phase runs back to back on both sides
      gap_pct   = (phase == 1) ? 0 : 22;
      stall_pct = (phase == 1) ? 0 : 22;
      repeat (95) begin
        if (arr_left == 0)
          arr_left = ($urandom_range(7) == 0) ? $urandom_range(25, 60)
                                              : $urandom_range(1, 24);
        send_element(random_element(), arr_left == 1);
        arr_left--;
      end
      drain_stream();
    end
    gap_pct   = 22;
    stall_pct = 22;
  endtask

  // Output held off for a long stretch while items keep coming
  task automatic test_output_backpressure();
    reg_write(ADDR_MAX_RUN_LEN, 32'd4);
    hold_request = 400;
    repeat (40) send_element(random_element(), $urandom_range(7) == 0);
    drain_stream();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    dp_clear();
    run_len_cfg = 5'd1;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_run_length_limits();
    test_random_arrays();
    test_output_backpressure();

    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("partition_max_sum_dp: match");
    end else begin
      $display("partition_max_sum_dp: mismatch");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("partition_max_sum_dp: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
rtl/pmsd_pkg.sv
rtl/pmsd_cell.sv
rtl/partition_max_sum_dp.sv
rtl/pmsd_checker.sv
tb/partition_max_sum_dp_tb.sv
